@@ sv/aabb_affine_transform_assert.svh @@
// assertion macros shared by the rtl
`ifndef AABB_AFFINE_TRANSFORM_ASSERT_SVH
`define AABB_AFFINE_TRANSFORM_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define AABB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define AABB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/aabb_pkg.sv @@
package aabb_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int NUM_REGS  = 6;
	localparam int IDX_WIDTH = 3;

	localparam logic [IDX_WIDTH-1:0] REG_ROW_X_LIN_A = 3'd0;
	localparam logic [IDX_WIDTH-1:0] REG_ROW_X_LIN_B = 3'd1;
	localparam logic [IDX_WIDTH-1:0] REG_ROW_Y_LIN_A = 3'd2;
	localparam logic [IDX_WIDTH-1:0] REG_ROW_Y_LIN_B = 3'd3;
	localparam logic [IDX_WIDTH-1:0] REG_ROW_Z_LIN_A = 3'd4;
	localparam logic [IDX_WIDTH-1:0] REG_ROW_Z_LIN_B = 3'd5;

	// identity transform
	localparam logic [63:0] RST_ROW_X_LIN_A = 64'h0000_0000_0001_0000;
	localparam logic [63:0] RST_ROW_X_LIN_B = 64'h0000_0000_0000_0000;
	localparam logic [63:0] RST_ROW_Y_LIN_A = 64'h0001_0000_0000_0000;
	localparam logic [63:0] RST_ROW_Y_LIN_B = 64'h0000_0000_0000_0000;
	localparam logic [63:0] RST_ROW_Z_LIN_A = 64'h0000_0000_0000_0000;
	localparam logic [63:0] RST_ROW_Z_LIN_B = 64'h0000_0000_0001_0000;

	typedef struct packed {
		logic signed [31:0] in_min_x;
		logic signed [31:0] in_min_y;
		logic signed [31:0] in_min_z;
		logic signed [31:0] in_max_x;
		logic signed [31:0] in_max_y;
		logic signed [31:0] in_max_z;
	} aabb_box_t;

	typedef struct packed {
		logic signed [31:0] out_min_x;
		logic signed [31:0] out_min_y;
		logic signed [31:0] out_min_z;
		logic signed [31:0] out_max_x;
		logic signed [31:0] out_max_y;
		logic signed [31:0] out_max_z;
	} aabb_result_t;

endpackage

@@ sv/aabb_affine_transform.sv @@
// an accepted box beat passes through the four registered stages to its result beat
// throughput: one box per cycle, set by the 18 parallel coordinate-by-weight
// multipliers of stage one; the four stages advance together and hold on stall
// reset: arst_n low clears every stage valid bit and the output valid, and loads
// the identity transform into the six row registers; payload registers keep junk
module aabb_affine_transform #(
	parameter int COORD_WIDTH = aabb_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = aabb_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// box channel
	input  logic                                box_valid,
	output logic                                box_stall,
	input  aabb_pkg::aabb_box_t                 box,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output aabb_pkg::aabb_result_t              result,
	// register write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [aabb_pkg::IDX_WIDTH-1:0]      cfg_index,
	input  logic [63:0]                         cfg_data
);
	import aabb_pkg::*;

	`include "aabb_affine_transform_assert.svh"

	// product and sum widths: three products plus the shifted translation
	// and the rounding half fit with three guard bits
	localparam int PW = 2 * COORD_WIDTH;
	localparam int SW = PW + 3;

	localparam logic signed [SW-1:0] HALF = (SW'(1) << FRAC_BITS) >>> 1;
	localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
	localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

	// ---------------------------------------------------------------
	// transform registers
	// ---------------------------------------------------------------
	logic [63:0] row_q [NUM_REGS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[REG_ROW_X_LIN_A] <= RST_ROW_X_LIN_A;
			row_q[REG_ROW_X_LIN_B] <= RST_ROW_X_LIN_B;
			row_q[REG_ROW_Y_LIN_A] <= RST_ROW_Y_LIN_A;
			row_q[REG_ROW_Y_LIN_B] <= RST_ROW_Y_LIN_B;
			row_q[REG_ROW_Z_LIN_A] <= RST_ROW_Z_LIN_A;
			row_q[REG_ROW_Z_LIN_B] <= RST_ROW_Z_LIN_B;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_X_LIN_A: row_q[REG_ROW_X_LIN_A] <= cfg_data;
				REG_ROW_X_LIN_B: row_q[REG_ROW_X_LIN_B] <= cfg_data;
				REG_ROW_Y_LIN_A: row_q[REG_ROW_Y_LIN_A] <= cfg_data;
				REG_ROW_Y_LIN_B: row_q[REG_ROW_Y_LIN_B] <= cfg_data;
				REG_ROW_Z_LIN_A: row_q[REG_ROW_Z_LIN_A] <= cfg_data;
				REG_ROW_Z_LIN_B: row_q[REG_ROW_Z_LIN_B] <= cfg_data;
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// weights per row and axis, translation per row; only the low
	// COORD_WIDTH bits of each half count, taken as signed
	logic signed [COORD_WIDTH-1:0] wgt [3][3];
	logic signed [COORD_WIDTH-1:0] trn [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			wgt[r][0] = row_q[2*r][COORD_WIDTH-1:0];
			wgt[r][1] = row_q[2*r][32 +: COORD_WIDTH];
			wgt[r][2] = row_q[2*r+1][COORD_WIDTH-1:0];
			trn[r]    = row_q[2*r+1][32 +: COORD_WIDTH];
		end
	end

	// ---------------------------------------------------------------
	// stall control: the whole pipe moves whenever the output slot is
	// free or being emptied this cycle
	// ---------------------------------------------------------------
	logic advance;
	logic valid_s1, valid_s2, valid_s3;

	assign advance   = !result_valid || !result_stall;
	assign box_stall = !advance;

	// ---------------------------------------------------------------
	// stage 1: each weight times the low and high coordinate on its axis
	// ---------------------------------------------------------------
	logic signed [COORD_WIDTH-1:0] lo_c [3];
	logic signed [COORD_WIDTH-1:0] hi_c [3];

	always_comb begin
		lo_c[0] = box.in_min_x[COORD_WIDTH-1:0];
		lo_c[1] = box.in_min_y[COORD_WIDTH-1:0];
		lo_c[2] = box.in_min_z[COORD_WIDTH-1:0];
		hi_c[0] = box.in_max_x[COORD_WIDTH-1:0];
		hi_c[1] = box.in_max_y[COORD_WIDTH-1:0];
		hi_c[2] = box.in_max_z[COORD_WIDTH-1:0];
	end

	logic signed [PW-1:0] plo_s1 [3][3];
	logic signed [PW-1:0] phi_s1 [3][3];

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < 3; r++) begin
				for (int a = 0; a < 3; a++) begin
					plo_s1[r][a] <= PW'(wgt[r][a]) * PW'(lo_c[a]);
					phi_s1[r][a] <= PW'(wgt[r][a]) * PW'(hi_c[a]);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 2: the corners span every mix of low and high per axis, so
	// the extreme sum takes the smaller or larger product of each term
	// ---------------------------------------------------------------
	logic signed [PW-1:0] mn_s2 [3][3];
	logic signed [PW-1:0] mx_s2 [3][3];

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < 3; r++) begin
				for (int a = 0; a < 3; a++) begin
					if (plo_s1[r][a] < phi_s1[r][a]) begin
						mn_s2[r][a] <= plo_s1[r][a];
						mx_s2[r][a] <= phi_s1[r][a];
					end else begin
						mn_s2[r][a] <= phi_s1[r][a];
						mx_s2[r][a] <= plo_s1[r][a];
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 3: full-width sum with translation and rounding half;
	// rounding and saturation are monotone, so they commute with min/max
	// ---------------------------------------------------------------
	logic signed [SW-1:0] smn_s3 [3];
	logic signed [SW-1:0] smx_s3 [3];

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < 3; r++) begin
				smn_s3[r] <= SW'(mn_s2[r][0]) + SW'(mn_s2[r][1]) + SW'(mn_s2[r][2])
					+ (SW'(trn[r]) <<< FRAC_BITS) + HALF;
				smx_s3[r] <= SW'(mx_s2[r][0]) + SW'(mx_s2[r][1]) + SW'(mx_s2[r][2])
					+ (SW'(trn[r]) <<< FRAC_BITS) + HALF;
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 4: drop fraction bits and saturate into the output register
	// ---------------------------------------------------------------
	function automatic logic signed [31:0] round_sat(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] q;
		logic signed [SW-1:0] c;
		q = s >>> FRAC_BITS;
		if (q > MAXV) begin
			c = MAXV;
		end else if (q < MINV) begin
			c = MINV;
		end else begin
			c = q;
		end
		return 32'(signed'(c[COORD_WIDTH-1:0]));
	endfunction

	always_ff @(posedge clk) begin
		if (advance) begin
			result.out_min_x <= round_sat(smn_s3[0]);
			result.out_min_y <= round_sat(smn_s3[1]);
			result.out_min_z <= round_sat(smn_s3[2]);
			result.out_max_x <= round_sat(smx_s3[0]);
			result.out_max_y <= round_sat(smx_s3[1]);
			result.out_max_z <= round_sat(smx_s3[2]);
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			result_valid <= 1'b0;
		end else if (advance) begin
			valid_s1     <= box_valid;
			valid_s2     <= valid_s1;
			valid_s3     <= valid_s2;
			result_valid <= valid_s3;
		end
	end

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	`AABB_ASSERT_SAME(a_stall_only_when_full, clk, arst_n, box_stall,
		result_valid && result_stall, "box stalled with a free output slot")
	`AABB_ASSERT_NEXT(a_accept_enters, clk, arst_n, box_valid && !box_stall,
		valid_s1, "accepted box beat lost at stage one")
	`AABB_ASSERT_NEXT(a_s3_reaches_out, clk, arst_n, valid_s3 && advance,
		result_valid, "stage three beat did not reach the output")
	`AABB_ASSERT_SAME(a_min_not_above_max, clk, arst_n, result_valid,
		(result.out_min_x <= result.out_max_x) && (result.out_min_y <= result.out_max_y)
		&& (result.out_min_z <= result.out_max_z), "result minimum above maximum")

endmodule
